// ----- hdl/cnrc_pkg.sv -----
// ----------------------------------------------------------------------------
// cnrc_pkg: shared types and constants for the nearest reference classifier
// Holds the word formats, the scan sequencer states and the power-up
// reference colors.
// ----------------------------------------------------------------------------
package cnrc_pkg;

  // Table geometry and channel width.
  localparam int NumColors  = 9;
  localparam int SampleBits = 10;
  localparam int IdxW       = (NumColors > 1) ? $clog2(NumColors) : 1;
  localparam int SqW        = 2 * SampleBits;
  localparam int SumW       = SqW + 2;
  localparam int DistW      = 22;
  localparam int EntryW     = 4 * SampleBits;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // Command codes.
  localparam logic CmdClassify = 1'b0;
  localparam logic CmdCorrect  = 1'b1;

  // One reference entry.
  typedef struct packed {
    logic [SampleBits-1:0] red;
    logic [SampleBits-1:0] green;
    logic [SampleBits-1:0] blue;
    logic [SampleBits-1:0] clear;
  } entry_t;

  // Input word.
  typedef struct packed {
    logic                  cmd;
    logic [SampleBits-1:0] sample_red;
    logic [SampleBits-1:0] sample_green;
    logic [SampleBits-1:0] sample_blue;
    logic [SampleBits-1:0] sample_clear;
    logic [3:0]            color_index;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [3:0]       nearest_color;
    logic [DistW-1:0] min_distance;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT,
    ST_CORR
  } cnrc_state_e;

  // Power-up reference colors: none, red, orange, yellow, green, blue,
  // violet, pink, brown. Further slots start at zero.
  function automatic entry_t reset_entry(input logic [3:0] idx);
    entry_t e;
    e = '0;
    case (idx)
      4'd0:    e = '{red: SampleBits'(80),  green: SampleBits'(80),
                     blue: SampleBits'(60),  clear: SampleBits'(90)};
      4'd1:    e = '{red: SampleBits'(348), green: SampleBits'(127),
                     blue: SampleBits'(81),  clear: SampleBits'(241)};
      4'd2:    e = '{red: SampleBits'(386), green: SampleBits'(165),
                     blue: SampleBits'(96),  clear: SampleBits'(279)};
      4'd3:    e = '{red: SampleBits'(406), green: SampleBits'(316),
                     blue: SampleBits'(147), clear: SampleBits'(373)};
      4'd4:    e = '{red: SampleBits'(257), green: SampleBits'(290),
                     blue: SampleBits'(143), clear: SampleBits'(294)};
      4'd5:    e = '{red: SampleBits'(245), green: SampleBits'(325),
                     blue: SampleBits'(282), clear: SampleBits'(353)};
      4'd6:    e = '{red: SampleBits'(209), green: SampleBits'(230),
                     blue: SampleBits'(228), clear: SampleBits'(283)};
      4'd7:    e = '{red: SampleBits'(296), green: SampleBits'(188),
                     blue: SampleBits'(182), clear: SampleBits'(285)};
      4'd8:    e = '{red: SampleBits'(219), green: SampleBits'(147),
                     blue: SampleBits'(109), clear: SampleBits'(203)};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ----- hdl/cnrc_ram.sv -----
// ----------------------------------------------------------------------------
// cnrc_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module cnrc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/color_nearest_reference_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// color_nearest_reference_classifier_unit: nearest reference color search
// Keeps a table of reference colors in a RAM and classifies sensor samples
// by the smallest squared RGB(+clear) distance; corrects entries in place.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one word per
//   command. A classify word scans all NumColors entries and yields one result
//   word on the output channel (out_valid_o / out_stall_i / out_data_o). A
//   correct word blends the sample into the named entry, 7/8 old plus 1/8
//   new per channel, and yields no result; an index beyond the table is
//   dropped.
//   The scan reads one RAM entry per cycle through a three-stage path (RAM
//   read, per-channel squares, sum and compare) before the result is handed
//   to the output register; a correct reads the entry, then writes it back.
//   Items are processed one at a time; in_stall_o is high while an item is
//   in progress.
//   A finished result sits in the output register; the next item is taken
//   while it waits, and a following result holds until out_stall_i drops.
//   The config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets the
//   clear-channel enable and is always ready.
//   Reset clears all control state and per-entry valid bits, so every entry
//   reads as its power-up reference color until first corrected. No clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module color_nearest_reference_classifier_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cnrc_pkg::in_word_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cnrc_pkg::out_word_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  import cnrc_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumColors - 1);

  cnrc_state_e        state_q, state_d;
  logic [IdxW-1:0]    scan_cnt_q, scan_cnt_d;
  in_word_t           smp_q;
  logic               use_clear_q;
  logic [NumColors-1:0] valid_q;

  // RAM port signals.
  logic               ram_re;
  logic [IdxW-1:0]    ram_raddr;
  logic               ram_we;
  logic [EntryW-1:0]  ram_rdata;
  entry_t             wr_entry;

  // Pipeline registers.
  logic               rd_vld_q;
  logic [IdxW-1:0]    rd_idx_q;
  logic               sq_vld_q;
  logic [IdxW-1:0]    sq_idx_q;
  logic [SqW-1:0]     sq_q [4];
  logic [SumW-1:0]    best_q;
  logic [IdxW-1:0]    best_idx_q;
  logic               scan_rd;
  logic               out_load;
  logic               out_valid_q;
  out_word_t          out_q;

  entry_t             cur_entry;
  logic [SampleBits-1:0] ref_ch [4];
  logic [SampleBits-1:0] smp_ch [4];
  logic [SampleBits-1:0] diff [4];
  logic [SqW-1:0]     sq_d [4];
  logic [SumW-1:0]    dist_sum;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_clear_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      use_clear_q <= cfg_data_i;
    end
  end

  // Reference table storage.
  cnrc_ram #(
    .Width (EntryW),
    .Depth (NumColors)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rd_idx_q),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries never written read as their power-up color.
  assign cur_entry = valid_q[rd_idx_q] ? entry_t'(ram_rdata) : reset_entry(4'(rd_idx_q));

  assign ref_ch[0] = cur_entry.red;
  assign ref_ch[1] = cur_entry.green;
  assign ref_ch[2] = cur_entry.blue;
  assign ref_ch[3] = cur_entry.clear;
  assign smp_ch[0] = smp_q.sample_red;
  assign smp_ch[1] = smp_q.sample_green;
  assign smp_ch[2] = smp_q.sample_blue;
  assign smp_ch[3] = smp_q.sample_clear;

  // Per-channel absolute difference and square.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      diff[c] = (ref_ch[c] > smp_ch[c]) ? (ref_ch[c] - smp_ch[c]) : (smp_ch[c] - ref_ch[c]);
      sq_d[c] = SqW'(diff[c]) * SqW'(diff[c]);
    end
    if (!use_clear_q) begin
      sq_d[3] = '0;
    end
  end

  // Correction blend: (7*old + new) >> 3 on each channel.
  always_comb begin
    logic [SampleBits+2:0] acc [4];
    for (int c = 0; c < 4; c++) begin
      acc[c] = ({ref_ch[c], 3'b000} - (SampleBits+3)'(ref_ch[c]))
             + (SampleBits+3)'(smp_ch[c]);
    end
    wr_entry.red   = acc[0][SampleBits+2:3];
    wr_entry.green = acc[1][SampleBits+2:3];
    wr_entry.blue  = acc[2][SampleBits+2:3];
    wr_entry.clear = acc[3][SampleBits+2:3];
  end

  assign ram_we = (state_q == ST_CORR);

  // Sequencer: next state, RAM read requests and result hand-off.
  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    ram_re     = 1'b0;
    ram_raddr  = scan_cnt_q;
    scan_rd    = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.cmd == CmdClassify) begin
            ram_re     = 1'b1;
            ram_raddr  = '0;
            scan_rd    = 1'b1;
            scan_cnt_d = IdxW'(1);
            state_d    = ST_SCAN;
          end else if ({1'b0, in_data_i.color_index} < 5'(NumColors)) begin
            ram_re    = 1'b1;
            ram_raddr = IdxW'(in_data_i.color_index);
            state_d   = ST_CORR;
          end
        end
      end
      ST_SCAN: begin
        ram_re  = 1'b1;
        scan_rd = 1'b1;
        if (scan_cnt_q == LastIdx) begin
          state_d = ST_DRAIN;
        end else begin
          scan_cnt_d = scan_cnt_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        if (sq_vld_q && (sq_idx_q == LastIdx)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_CORR: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
    end
  end

  // Accepted sample.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      smp_q <= in_data_i;
    end
  end

  // Per-entry written flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[rd_idx_q] <= 1'b1;
    end
  end

  // Pipeline control: read tag and square stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      sq_vld_q <= 1'b0;
      sq_idx_q <= '0;
    end else begin
      rd_vld_q <= scan_rd;
      if (ram_re) begin
        rd_idx_q <= ram_raddr;
      end
      sq_vld_q <= rd_vld_q;
      sq_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      for (int c = 0; c < 4; c++) begin
        sq_q[c] <= sq_d[c];
      end
    end
  end

  // Sum and running minimum; entry zero always seeds the search.
  assign dist_sum = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]) + SumW'(sq_q[3]);

  always_ff @(posedge clk_i) begin
    if (sq_vld_q && ((sq_idx_q == '0) || (dist_sum < best_q))) begin
      best_q     <= dist_sum;
      best_idx_q <= sq_idx_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.nearest_color <= 4'(best_idx_q);
      out_q.min_distance  <= (64'(best_q) > 64'(DistMax)) ? DistMax : DistW'(best_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result appears only when the sequencer hands one off.
  a_out_from_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside hand-off");

  // A correction write never overlaps a scan in flight.
  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!rd_vld_q && !sq_vld_q))
    else $error("table write during scan");

  // Scan reads stay inside the table.
  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ({1'b0, rd_idx_q} < (IdxW+1)'(NumColors)))
    else $error("scan index out of range");

endmodule

// ----- tb/color_match_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_match_checker: scoreboard for the nearest reference color classifier
// Watches the input, output and configuration channels. It keeps its own
// copy of the reference table and the clear-channel enable. It predicts the
// nearest entry for every classify word and compares each result word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module color_match_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  cnrc_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cnrc_pkg::out_word_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,
  output int                  error_count_o,
  output int                  pending_o,
  output int                  classify_count_o,
  output int                  correct_count_o,
  output int                  result_count_o
);
  import cnrc_pkg::*;

  // Predicted reference table and clear-channel enable.
  entry_t    ref_colors [NumColors];
  logic      clear_en;
  out_word_t expected_matches [$];

  int        errors;
  int        classifies;
  int        corrects;
  int        results;
  int        slot;
  out_word_t want;

  // Reference colors loaded at power-up.
  function automatic entry_t power_up_color(input int idx);
    entry_t e;
    e = '0;
    case (idx)
      0: e = {10'd80,  10'd80,  10'd60,  10'd90};
      1: e = {10'd348, 10'd127, 10'd81,  10'd241};
      2: e = {10'd386, 10'd165, 10'd96,  10'd279};
      3: e = {10'd406, 10'd316, 10'd147, 10'd373};
      4: e = {10'd257, 10'd290, 10'd143, 10'd294};
      5: e = {10'd245, 10'd325, 10'd282, 10'd353};
      6: e = {10'd209, 10'd230, 10'd228, 10'd283};
      7: e = {10'd296, 10'd188, 10'd182, 10'd285};
      8: e = {10'd219, 10'd147, 10'd109, 10'd203};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Squared difference of one channel.
  function automatic int unsigned sq_gap(input logic [SampleBits-1:0] a,
                                         input logic [SampleBits-1:0] b);
    int unsigned d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // One channel moved an eighth of the way toward the sample.
  function automatic logic [SampleBits-1:0] blend_chan(input logic [SampleBits-1:0] old_v,
                                                       input logic [SampleBits-1:0] new_v);
    int unsigned s;
    s = 7 * old_v + new_v;
    return SampleBits'(s >> 3);
  endfunction

  // Scan the predicted table; the first entry seeds the search and a later
  // one wins only with a strictly smaller distance.
  function automatic out_word_t nearest_reference(input in_word_t w);
    out_word_t   res;
    int unsigned gap_sum;
    int unsigned best_dist;
    int          best_idx;
    int          i;
    best_dist = 0;
    best_idx  = 0;
    for (i = 0; i < NumColors; i++) begin
      gap_sum = sq_gap(ref_colors[i].red,   w.sample_red)
              + sq_gap(ref_colors[i].green, w.sample_green)
              + sq_gap(ref_colors[i].blue,  w.sample_blue);
      if (clear_en) begin
        gap_sum += sq_gap(ref_colors[i].clear, w.sample_clear);
      end
      if (i == 0 || gap_sum < best_dist) begin
        best_dist = gap_sum;
        best_idx  = i;
      end
    end
    res.nearest_color = 4'(best_idx);
    res.min_distance  = (best_dist > DistMax) ? DistMax : DistW'(best_dist);
    return res;
  endfunction

  // Channel monitor: results are checked before the word accepted at the
  // same edge is predicted, since that result belongs to an older word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (slot = 0; slot < NumColors; slot++) begin
        ref_colors[slot] = power_up_color(slot);
      end
      clear_en = 1'b0;
      expected_matches.delete();
      errors     = 0;
      classifies = 0;
      corrects   = 0;
      results    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (expected_matches.size() == 0) begin
          $error("unexpected result word: nearest_color %0d, min_distance %0d",
                 out_data_i.nearest_color, out_data_i.min_distance);
          errors++;
        end else begin
          want = expected_matches.pop_front();
          if (out_data_i.nearest_color !== want.nearest_color) begin
            $error("nearest_color mismatch: expected %0d, actual %0d",
                   want.nearest_color, out_data_i.nearest_color);
            errors++;
          end
          if (out_data_i.min_distance !== want.min_distance) begin
            $error("min_distance mismatch: expected %0d, actual %0d",
                   want.min_distance, out_data_i.min_distance);
            errors++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        clear_en = cfg_data_i;
      end

      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.cmd == CmdCorrect) begin
          corrects++;
          // An index past the table leaves it untouched.
          if (in_data_i.color_index < NumColors) begin
            slot = in_data_i.color_index;
            ref_colors[slot].red   = blend_chan(ref_colors[slot].red,   in_data_i.sample_red);
            ref_colors[slot].green = blend_chan(ref_colors[slot].green, in_data_i.sample_green);
            ref_colors[slot].blue  = blend_chan(ref_colors[slot].blue,  in_data_i.sample_blue);
            ref_colors[slot].clear = blend_chan(ref_colors[slot].clear, in_data_i.sample_clear);
          end
        end else begin
          classifies++;
          expected_matches.push_back(nearest_reference(in_data_i));
        end
      end
    end
    error_count_o    <= errors;
    pending_o        <= expected_matches.size();
    classify_count_o <= classifies;
    correct_count_o  <= corrects;
    result_count_o   <= results;
  end

endmodule

// ----- tb/tb_color_nearest_reference_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_nearest_reference_classifier_unit: stimulus and verdict
// Drives directed classify and correct words, then three random phases with
// different sender and receiver pacing, and toggles the clear-channel enable
// between phases. Checking is done by the scoreboard module beside the block.
// ----------------------------------------------------------------------------
module tb_color_nearest_reference_classifier_unit;
  import cnrc_pkg::*;

  localparam int SettleCycles = 20;
  localparam int ChanMax      = (1 << SampleBits) - 1;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  int error_count;
  int pending;
  int classify_count;
  int correct_count;
  int result_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  color_nearest_reference_classifier_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  color_match_checker scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .error_count_o    (error_count),
    .pending_o        (pending),
    .classify_count_o (classify_count),
    .correct_count_o  (correct_count),
    .result_count_o   (result_count)
  );

  // 8 ns clock.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic in_word_t make_word(input logic cmd, input int r, input int g,
                                         input int b, input int c, input int idx);
    in_word_t w;
    w.cmd          = cmd;
    w.sample_red   = SampleBits'(r);
    w.sample_green = SampleBits'(g);
    w.sample_blue  = SampleBits'(b);
    w.sample_clear = SampleBits'(c);
    w.color_index  = 4'(idx);
    return w;
  endfunction

  // One channel: near a power-up color, anywhere, or at a rail.
  function automatic logic [SampleBits-1:0] pick_chan(input logic [SampleBits-1:0] base,
                                                      input int mode);
    int v;
    if (mode < 50) begin
      v = int'(base) + int'($urandom_range(0, 80)) - 40;
      if (v < 0) v = 0;
      if (v > ChanMax) v = ChanMax;
    end else if (mode < 85) begin
      v = $urandom_range(0, ChanMax);
    end else begin
      v = $urandom_range(0, 1) ? ChanMax : 0;
    end
    return SampleBits'(v);
  endfunction

  // Random word: mostly classify, with corrections that drift the table.
  function automatic in_word_t random_word();
    in_word_t w;
    entry_t   base;
    int       mode;
    base = reset_entry(4'($urandom_range(0, NumColors - 1)));
    mode = $urandom_range(0, 99);
    w.cmd = ($urandom_range(0, 99) < 40) ? CmdCorrect : CmdClassify;
    if ($urandom_range(0, 99) < 85) begin
      w.color_index = 4'($urandom_range(0, NumColors - 1));
    end else begin
      w.color_index = 4'($urandom_range(NumColors, 15));
    end
    w.sample_red   = pick_chan(base.red, mode);
    w.sample_green = pick_chan(base.green, mode);
    w.sample_blue  = pick_chan(base.blue, mode);
    w.sample_clear = pick_chan(base.clear, mode);
    return w;
  endfunction

  // Present one word, with a random gap first, and hold it until taken.
  task automatic send_word(input in_word_t w);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(posedge clk_i);
    end while (in_stall);
  endtask

  // Stop sending until every predicted result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Set the clear-channel enable once the block has gone quiet; a correct
  // word may still be writing back after the last result.
  task automatic set_clear_enable(input logic en);
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int count, input int send_pct, input int recv_pct);
    int k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (k = 0; k < count; k++) begin
      send_word(random_word());
      // Hold off once mid-phase until the output side has caught up.
      if (k == count / 2) begin
        wait_for_results();
      end
    end
  endtask

  // Main sequence.
  initial begin
    entry_t e;
    int     k;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words with the clear channel left out.
    send_idle_pct = 31;
    recv_idle_pct = 85;
    send_word(make_word(CmdClassify, 0, 0, 0, 0, 0));
    send_word(make_word(CmdClassify, ChanMax, ChanMax, ChanMax, ChanMax, 15));
    for (k = 0; k < NumColors; k++) begin
      e = reset_entry(4'(k));
      send_word(make_word(CmdClassify, e.red, e.green, e.blue, e.clear, 8 - k));
    end
    // Equal distance to entries four and five; the lower index must win.
    send_word(make_word(CmdClassify, 238, 309, 211, 0, 5));
    // The first two corrections fall past the table and change nothing; the next two blend into entries zero and eight.
    send_word(make_word(CmdCorrect, ChanMax, ChanMax, ChanMax, ChanMax, NumColors));
    send_word(make_word(CmdCorrect, 0, 0, 0, 0, 15));
    send_word(make_word(CmdCorrect, ChanMax, ChanMax, ChanMax, ChanMax, 0));
    send_word(make_word(CmdCorrect, 0, 0, 0, 0, NumColors - 1));
    send_word(make_word(CmdClassify, 80, 80, 60, 90, 0));
    send_word(make_word(CmdClassify, ChanMax, ChanMax, ChanMax, 0, 7));

    // Directed words with the clear channel counted.
    set_clear_enable(1'b1);
    send_word(make_word(CmdClassify, 0, 0, 0, ChanMax, 3));
    send_word(make_word(CmdClassify, ChanMax, ChanMax, ChanMax, 0, 10));
    e = reset_entry(4'd5);
    send_word(make_word(CmdClassify, e.red, e.green, e.blue, e.clear, 1));
    send_word(make_word(CmdCorrect, 257, 290, 143, ChanMax, 4));
    send_word(make_word(CmdClassify, 238, 309, 211, 323, 12));

    // Random traffic under three pacing modes.
    random_phase(175, 31, 85);
    set_clear_enable(1'b0);
    random_phase(175, 85, 31);
    set_clear_enable(1'b1);
    random_phase(175, 0, 0);

    wait_for_results();
    repeat (30) @(posedge clk_i);

    $display("Covered %0d classify and %0d correct words, %0d result words compared.",
             classify_count, correct_count, result_count);
    $display("Clear channel off and on; idle mixes 31/85, 85/31 and none.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
